/* design/geodetic_to_ecef_macros.svh */
// Assertion macros used by the geodetic to ECEF top level.
`ifndef GEODETIC_TO_ECEF_MACROS_SVH
`define GEODETIC_TO_ECEF_MACROS_SVH
`ifndef SYNTHESIS
`define GTE_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("gte: same-cycle check failed");
`define GTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("gte: next-cycle check failed");
`else
`define GTE_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define GTE_ASSERT_NEXT(lbl, clk, rstn, ante, cons)
`endif
`endif

/* design/gte_pkg.sv */
// Types, constants and elaboration-time table functions for the geodetic to ECEF block.
`default_nettype none
package gte_pkg;

    localparam int LAT_W = 31;
    localparam int LON_W = 32;
    localparam int ALT_W = 27;
    localparam int OUT_W = 34;

    localparam int CORDIC_STAGES = 32;
    localparam int PH_STAGES     = 3;
    localparam int PH_SHIFT      = 76;
    localparam int NEWTON_STEPS  = 6;

    localparam int STEP_S2      = 0;
    localparam int STEP_T       = 1;
    localparam int STEP_NEWTON0 = 2;
    localparam int STEP_NQ      = STEP_NEWTON0 + 3 * NEWTON_STEPS;
    localparam int STEP_M       = STEP_NQ + 1;
    localparam int STEP_X       = STEP_M + 1;
    localparam int NSTEP        = STEP_X + 1;

    localparam logic [63:0] Q60_ONE       = 64'h1000_0000_0000_0000;
    localparam logic [63:0] THREE_Q60     = 64'h3000_0000_0000_0000;
    localparam logic [63:0] TWO_PI_Q60    = 64'h6487_ED51_10B4_611B;
    localparam logic [63:0] E2_Q60        = 64'd7718094650639641;
    localparam logic [63:0] ONE_MINUS_E2  = Q60_ONE - E2_Q60;
    localparam logic [63:0] SEMI_MAJOR_MM = 64'd6378137000;
    localparam logic [63:0] GAIN_SEED     = 64'd691752902764108186;
    localparam logic [31:0] PH_HALF       = 32'd1800000000;
    localparam logic [31:0] PH_EIGHTH     = 32'h2000_0000;

    // 3.6e9 = 2^10 * 3515625: drop ten bits, then multiply by a rounded-up reciprocal
    localparam logic [127:0] PH_ODD_DIV = 128'd3515625;
    localparam logic [63:0]  PH_BIAS    = 64'(PH_HALF >> 10);
    localparam logic [63:0]  PH_RECIP   = 64'(((128'd1 << PH_SHIFT) / PH_ODD_DIV) + 128'd1);

    localparam logic [127:0] RND40 = 128'd1 << 39;
    localparam logic [127:0] RND60 = 128'd1 << 59;
    localparam logic [127:0] RND80 = 128'd1 << 79;

    localparam logic [1:0] QUAD_E = 2'd0;
    localparam logic [1:0] QUAD_N = 2'd1;
    localparam logic [1:0] QUAD_W = 2'd2;

    typedef struct packed {
        logic                    valid;
        logic signed [ALT_W-1:0] alt;
        logic signed [63:0]      sl;
        logic signed [63:0]      cl;
        logic signed [63:0]      so;
        logic signed [63:0]      co;
        logic [63:0]             w;
        logic [63:0]             y;
        logic                    mneg;
        logic                    xneg;
        logic                    yneg;
        logic                    zneg;
    } gte_rec_t;

    function automatic logic [63:0] gte_abs(input logic signed [63:0] v);
        return v[63] ? (64'd0 - 64'(v)) : 64'(v);
    endfunction

    function automatic logic [63:0] gte_umul_shr(input logic [63:0] a, input logic [63:0] b,
                                                 input int f);
        logic [127:0] p;
        p = {64'd0, a} * {64'd0, b};
        p = p + (128'd1 << (f - 1));
        return 64'(p >> f);
    endfunction

    function automatic logic [63:0] gte_pow2_div(input int e, input int k);
        logic [63:0] rem;
        logic [63:0] quo;
        rem = '0;
        quo = '0;
        for (int b = 63; b >= 0; b--) begin
            rem = {rem[62:0], (b == e)};
            quo = {quo[62:0], 1'b0};
            if (rem >= 64'(k)) begin
                rem    = rem - 64'(k);
                quo[0] = 1'b1;
            end
        end
        return quo;
    endfunction

    function automatic logic [63:0] gte_turn(input int i);
        logic signed [63:0] sum;
        logic [63:0]        r;
        logic [63:0]        q;
        logic [63:0]        term;
        if (i == 0) begin
            return 64'd1 << 57;
        end
        sum = '0;
        for (int k = 1; k * i <= 60; k += 2) begin
            term = gte_pow2_div(60 - k * i, k);
            if (((k >> 1) & 1) != 0) begin
                sum = sum - $signed(term);
            end else begin
                sum = sum + $signed(term);
            end
        end
        r = 64'(sum);
        q = '0;
        for (int k = 0; k < 60; k++) begin
            r = r << 1;
            q = q << 1;
            if (r >= TWO_PI_Q60) begin
                r    = r - TWO_PI_Q60;
                q[0] = 1'b1;
            end
        end
        return q;
    endfunction

    function automatic logic [63:0] gte_inv_gain(input int stages);
        logic [63:0] p;
        logic [63:0] y;
        logic [63:0] u;
        p = Q60_ONE;
        for (int i = 0; i < stages; i++) begin
            if (2 * i < 64) begin
                p = p + (p >> (2 * i));
            end
        end
        y = GAIN_SEED;
        for (int n = 0; n < 8; n++) begin
            u = gte_umul_shr(p, gte_umul_shr(y, y, 60), 60);
            y = gte_umul_shr(y, THREE_Q60 - u, 60) >> 1;
        end
        return y;
    endfunction

    localparam logic [63:0] INV_GAIN = gte_inv_gain(CORDIC_STAGES);

endpackage
`default_nettype wire

/* design/gte_if.sv */
// Fix and result channel interfaces of the geodetic to ECEF block.
`default_nettype none
interface gte_in_if
    import gte_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [LAT_W-1:0] latitude;
    logic signed [LON_W-1:0] longitude;
    logic signed [ALT_W-1:0] altitude;

    modport source (output valid, output latitude, output longitude, output altitude,
                    input ready);
    modport sink   (input valid, input latitude, input longitude, input altitude,
                    output ready);
endinterface

interface gte_out_if
    import gte_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic signed [OUT_W-1:0] ecef_x;
    logic signed [OUT_W-1:0] ecef_y;
    logic signed [OUT_W-1:0] ecef_z;

    modport source (output valid, output ecef_x, output ecef_y, output ecef_z, input ready);
    modport sink   (input valid, input ecef_x, input ecef_y, input ecef_z, output ready);
endinterface
`default_nettype wire

/* design/gte_phase.sv */
// Angle to phase conversion: reciprocal multiplication by 1/3.6e9 for latitude and longitude.
`default_nettype none
module gte_phase
    import gte_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic signed [LAT_W-1:0] latitude,
    input  logic signed [LON_W-1:0] longitude,
    input  logic signed [ALT_W-1:0] altitude,
    output logic                    out_valid,
    output logic [1:0][31:0]        quo,
    output logic [1:0]              neg,
    output logic signed [ALT_W-1:0] alt
);

    logic [31:0]       lat_ext;
    logic [31:0]       lon_ext;
    logic [1:0][31:0]  mag;
    logic [127:0]      prod [2];

    logic                    valid_reg [PH_STAGES];
    logic signed [ALT_W-1:0] alt_reg   [PH_STAGES];
    logic [1:0]              neg_reg   [PH_STAGES];
    logic [63:0]             num_reg   [2];

    assign lat_ext = 32'(latitude);
    assign lon_ext = 32'(longitude);
    assign mag[0]  = lat_ext[31] ? (32'd0 - lat_ext) : lat_ext;
    assign mag[1]  = lon_ext[31] ? (32'd0 - lon_ext) : lon_ext;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < PH_STAGES; i++)
            begin
                valid_reg[i] <= 1'b0;
            end
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
            for (int i = 1; i < PH_STAGES; i++)
            begin
                valid_reg[i] <= valid_reg[i-1];
            end
        end
    end

    // (|v| * 2^32 + 1.8e9) / 2^10, truncated: the low ten bits of the half are dropped
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alt_reg[0] <= altitude;
            neg_reg[0] <= {lon_ext[31], lat_ext[31]};
            for (int l = 0; l < 2; l++)
            begin
                num_reg[l] <= {10'd0, mag[l], 22'd0} + PH_BIAS;
            end
            for (int i = 1; i < PH_STAGES; i++)
            begin
                alt_reg[i] <= alt_reg[i-1];
                neg_reg[i] <= neg_reg[i-1];
            end
        end
    end

    for (genvar l = 0; l < 2; l++)
    begin : g_recip
        gte_mul u_mul (
            .clk (clk),
            .en  (en),
            .a   (num_reg[l]),
            .b   (PH_RECIP),
            .rnd (128'd0),
            .p   (prod[l])
        );
    end

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            quo[l] = prod[l][PH_SHIFT+31:PH_SHIFT];
        end
    end

    assign out_valid = valid_reg[PH_STAGES-1];
    assign neg       = neg_reg[PH_STAGES-1];
    assign alt       = alt_reg[PH_STAGES-1];

endmodule
`default_nettype wire

/* design/gte_cordic.sv */
// Two-lane rotation CORDIC giving sine and cosine of latitude and longitude in Q60.
`default_nettype none
module gte_cordic
    import gte_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    en,
    input  logic                    in_valid,
    input  logic [1:0][31:0]        quo,
    input  logic [1:0]              neg,
    input  logic signed [ALT_W-1:0] in_alt,
    output logic                    out_valid,
    output logic signed [63:0]      sn [2],
    output logic signed [63:0]      cs [2],
    output logic signed [ALT_W-1:0] alt
);

    logic [1:0][31:0]   ph;
    logic [1:0][1:0]    quad;
    logic [1:0][31:0]   ru;

    logic                    valid_reg [CORDIC_STAGES+1];
    logic signed [ALT_W-1:0] alt_reg   [CORDIC_STAGES+1];
    logic [1:0][1:0]         quad_reg  [CORDIC_STAGES+1];
    logic signed [63:0]      x_reg     [CORDIC_STAGES+1][2];
    logic signed [63:0]      y_reg     [CORDIC_STAGES+1][2];
    logic signed [63:0]      z_reg     [CORDIC_STAGES+1][2];

    logic                    out_valid_reg;
    logic signed [ALT_W-1:0] out_alt_reg;
    logic signed [63:0]      sn_reg [2];
    logic signed [63:0]      cs_reg [2];

    always_comb
    begin
        for (int l = 0; l < 2; l++)
        begin
            ph[l]   = neg[l] ? (32'd0 - quo[l]) : quo[l];
            quad[l] = 2'((ph[l] + PH_EIGHTH) >> 30);
            ru[l]   = ph[l] - {quad[l], 30'd0};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            alt_reg[0]  <= in_alt;
            quad_reg[0] <= quad;
            for (int l = 0; l < 2; l++)
            begin
                x_reg[0][l] <= $signed(INV_GAIN);
                y_reg[0][l] <= '0;
                z_reg[0][l] <= $signed({{4{ru[l][31]}}, ru[l], 28'd0});
            end
        end
    end

    for (genvar i = 0; i < CORDIC_STAGES; i++)
    begin : g_rot
        localparam logic [63:0] ANG = gte_turn(i);

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[i+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[i+1] <= valid_reg[i];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                alt_reg[i+1]  <= alt_reg[i];
                quad_reg[i+1] <= quad_reg[i];
                for (int l = 0; l < 2; l++)
                begin
                    if (!z_reg[i][l][63])
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] - (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] + (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] - $signed(ANG);
                    end
                    else
                    begin
                        x_reg[i+1][l] <= x_reg[i][l] + (y_reg[i][l] >>> i);
                        y_reg[i+1][l] <= y_reg[i][l] - (x_reg[i][l] >>> i);
                        z_reg[i+1][l] <= z_reg[i][l] + $signed(ANG);
                    end
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= valid_reg[CORDIC_STAGES];
        end
    end

    // quadrant fold-back
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            out_alt_reg <= alt_reg[CORDIC_STAGES];
            for (int l = 0; l < 2; l++)
            begin
                case (quad_reg[CORDIC_STAGES][l])
                    QUAD_E:
                    begin
                        cs_reg[l] <= x_reg[CORDIC_STAGES][l];
                        sn_reg[l] <= y_reg[CORDIC_STAGES][l];
                    end
                    QUAD_N:
                    begin
                        cs_reg[l] <= -y_reg[CORDIC_STAGES][l];
                        sn_reg[l] <= x_reg[CORDIC_STAGES][l];
                    end
                    QUAD_W:
                    begin
                        cs_reg[l] <= -x_reg[CORDIC_STAGES][l];
                        sn_reg[l] <= -y_reg[CORDIC_STAGES][l];
                    end
                    default:
                    begin
                        cs_reg[l] <= y_reg[CORDIC_STAGES][l];
                        sn_reg[l] <= -x_reg[CORDIC_STAGES][l];
                    end
                endcase
            end
        end
    end

    assign out_valid = out_valid_reg;
    assign alt       = out_alt_reg;
    assign sn        = sn_reg;
    assign cs        = cs_reg;

endmodule
`default_nettype wire

/* design/gte_mul.sv */
// Two-stage 64 by 64 unsigned multiplier with rounding addend, 32-bit partial products.
`default_nettype none
module gte_mul
    import gte_pkg::*;
(
    input  logic         clk,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    input  logic [127:0] rnd,
    output logic [127:0] p
);

    logic [63:0]  pp00_reg;
    logic [63:0]  pp01_reg;
    logic [63:0]  pp10_reg;
    logic [63:0]  pp11_reg;
    logic [127:0] rnd_reg;
    logic [127:0] p_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pp00_reg <= {32'd0, a[31:0]}  * {32'd0, b[31:0]};
            pp01_reg <= {32'd0, a[31:0]}  * {32'd0, b[63:32]};
            pp10_reg <= {32'd0, a[63:32]} * {32'd0, b[31:0]};
            pp11_reg <= {32'd0, a[63:32]} * {32'd0, b[63:32]};
            rnd_reg  <= rnd;
            p_reg    <= {64'd0, pp00_reg} + {32'd0, pp01_reg, 32'd0}
                      + {32'd0, pp10_reg, 32'd0} + {pp11_reg, 64'd0} + rnd_reg;
        end
    end

    assign p = p_reg;

endmodule
`default_nettype wire

/* design/gte_step.sv */
// One multiply slot of the radius and projection chain, carrying the item record alongside.
`default_nettype none
module gte_step
    import gte_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         en,
    input  logic [63:0]  a,
    input  logic [63:0]  b,
    input  logic [127:0] rnd,
    input  gte_rec_t     rec_in,
    output logic [127:0] p,
    output gte_rec_t     rec_out
);

    gte_rec_t rec0_reg;
    gte_rec_t rec1_reg;

    gte_mul u_mul (
        .clk (clk),
        .en  (en),
        .a   (a),
        .b   (b),
        .rnd (rnd),
        .p   (p)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rec0_reg <= '0;
            rec1_reg <= '0;
        end
        else if (en)
        begin
            rec0_reg <= rec_in;
            rec1_reg <= rec0_reg;
        end
    end

    assign rec_out = rec1_reg;

endmodule
`default_nettype wire

/* design/geodetic_to_ecef.sv */
// Top level: WGS84 geodetic fix to ECEF coordinates, fully pipelined.
//
//  channel | dir | item fields                          | handshake
//  fix     | in  | latitude, longitude, altitude        | valid / ready
//  ecef    | out | ecef_x, ecef_y, ecef_z (mm, rounded) | valid / ready
//
// One fix per cycle unless the output stalls. Pipeline: 3 phase stages (input register and a
// reciprocal multiply), 34 CORDIC stages, 23 multiply slots (sin^2 and e2 terms, radius
// Newton steps and projection), one output register.
// Reset clears the valid bits and the carried records; no clearing pass, no tables to load.
// A stalled output register freezes the whole pipeline in place; ready drops only then.
`default_nettype none
`include "geodetic_to_ecef_macros.svh"
module geodetic_to_ecef
    import gte_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    gte_in_if.sink          fix,
    gte_out_if.source       ecef
);

    logic en;

    logic                    ph_valid;
    logic [1:0][31:0]        ph_quo;
    logic [1:0]              ph_neg;
    logic signed [ALT_W-1:0] ph_alt;

    logic                    cor_valid;
    logic signed [63:0]      cor_sn [2];
    logic signed [63:0]      cor_cs [2];
    logic signed [ALT_W-1:0] cor_alt;

    gte_rec_t     rec_in  [NSTEP];
    gte_rec_t     rec_out [NSTEP];
    logic [63:0]  op_a    [NSTEP];
    logic [63:0]  op_b    [NSTEP];
    logic [127:0] prod    [NSTEP];

    logic signed [63:0] altq;
    logic signed [63:0] nq;
    logic signed [63:0] h1;
    logic signed [63:0] h2;
    logic [63:0]        mmag;
    logic [127:0]       prod_h2;
    logic [127:0]       prod_y;
    logic [127:0]       prod_z;

    logic                    out_valid_reg;
    logic signed [OUT_W-1:0] ecef_x_reg;
    logic signed [OUT_W-1:0] ecef_y_reg;
    logic signed [OUT_W-1:0] ecef_z_reg;
    logic signed [OUT_W-1:0] ecef_x_next;
    logic signed [OUT_W-1:0] ecef_y_next;
    logic signed [OUT_W-1:0] ecef_z_next;

    assign en        = !out_valid_reg || ecef.ready;
    assign fix.ready = en;

    gte_phase u_phase (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (fix.valid),
        .latitude  (fix.latitude),
        .longitude (fix.longitude),
        .altitude  (fix.altitude),
        .out_valid (ph_valid),
        .quo       (ph_quo),
        .neg       (ph_neg),
        .alt       (ph_alt)
    );

    gte_cordic u_cordic (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (ph_valid),
        .quo       (ph_quo),
        .neg       (ph_neg),
        .in_alt    (ph_alt),
        .out_valid (cor_valid),
        .sn        (cor_sn),
        .cs        (cor_cs),
        .alt       (cor_alt)
    );

    for (genvar k = 0; k < NSTEP; k++)
    begin : g_step
        localparam logic [127:0] RND = (k == STEP_NQ) ? RND40 :
                                       ((k == STEP_X) ? RND80 : RND60);
        gte_step u_step (
            .clk     (clk),
            .rst_n   (rst_n),
            .en      (en),
            .a       (op_a[k]),
            .b       (op_b[k]),
            .rnd     (RND),
            .rec_in  (rec_in[k]),
            .p       (prod[k]),
            .rec_out (rec_out[k])
        );
    end

    // sin^2 of latitude
    always_comb
    begin
        rec_in[STEP_S2]       = '0;
        rec_in[STEP_S2].valid = cor_valid;
        rec_in[STEP_S2].alt   = cor_alt;
        rec_in[STEP_S2].sl    = cor_sn[0];
        rec_in[STEP_S2].cl    = cor_cs[0];
        rec_in[STEP_S2].so    = cor_sn[1];
        rec_in[STEP_S2].co    = cor_cs[1];
        op_a[STEP_S2]         = gte_abs(cor_sn[0]);
        op_b[STEP_S2]         = gte_abs(cor_sn[0]);
    end

    always_comb
    begin
        rec_in[STEP_T] = rec_out[STEP_S2];
        op_a[STEP_T]   = E2_Q60;
        op_b[STEP_T]   = prod[STEP_S2][123:60];
    end

    // Newton steps for 1/sqrt(w)
    for (genvar n = 0; n < NEWTON_STEPS; n++)
    begin : g_newton
        localparam int K = STEP_NEWTON0 + 3 * n;

        if (n == 0)
        begin : g_first
            always_comb
            begin
                rec_in[K]   = rec_out[K-1];
                rec_in[K].w = Q60_ONE - prod[K-1][123:60];
                rec_in[K].y = Q60_ONE;
            end
        end
        else
        begin : g_next
            always_comb
            begin
                rec_in[K]   = rec_out[K-1];
                rec_in[K].y = {1'b0, prod[K-1][123:61]};
            end
        end

        assign op_a[K] = rec_in[K].y;
        assign op_b[K] = rec_in[K].y;

        assign rec_in[K+1] = rec_out[K];
        assign op_a[K+1]   = rec_out[K].w;
        assign op_b[K+1]   = prod[K][123:60];

        assign rec_in[K+2] = rec_out[K+1];
        assign op_a[K+2]   = rec_out[K+1].y;
        assign op_b[K+2]   = THREE_Q60 - prod[K+1][123:60];
    end

    always_comb
    begin
        rec_in[STEP_NQ]   = rec_out[STEP_NQ-1];
        rec_in[STEP_NQ].y = {1'b0, prod[STEP_NQ-1][123:61]};
        op_a[STEP_NQ]     = SEMI_MAJOR_MM;
        op_b[STEP_NQ]     = rec_in[STEP_NQ].y;
    end

    // N with 20 fraction bits; h1 = N + h
    assign altq = 64'(rec_out[STEP_NQ].alt) <<< 20;
    assign nq   = $signed(prod[STEP_NQ][103:40]);
    assign h1   = nq + altq;

    always_comb
    begin
        rec_in[STEP_M]      = rec_out[STEP_NQ];
        rec_in[STEP_M].mneg = h1[63] ^ rec_out[STEP_NQ].cl[63];
        op_a[STEP_M]        = gte_abs(h1);
        op_b[STEP_M]        = gte_abs(rec_out[STEP_NQ].cl);
    end

    gte_mul u_mul_h2 (
        .clk (clk),
        .en  (en),
        .a   (64'(nq)),
        .b   (ONE_MINUS_E2),
        .rnd (RND60),
        .p   (prod_h2)
    );

    assign mmag = prod[STEP_M][123:60];
    assign h2   = $signed(prod_h2[123:60]) + (64'(rec_out[STEP_M].alt) <<< 20);

    always_comb
    begin
        rec_in[STEP_X]      = rec_out[STEP_M];
        rec_in[STEP_X].xneg = rec_out[STEP_M].mneg ^ rec_out[STEP_M].co[63];
        rec_in[STEP_X].yneg = rec_out[STEP_M].mneg ^ rec_out[STEP_M].so[63];
        rec_in[STEP_X].zneg = h2[63] ^ rec_out[STEP_M].sl[63];
        op_a[STEP_X]        = mmag;
        op_b[STEP_X]        = gte_abs(rec_out[STEP_M].co);
    end

    gte_mul u_mul_y (
        .clk (clk),
        .en  (en),
        .a   (mmag),
        .b   (gte_abs(rec_out[STEP_M].so)),
        .rnd (RND80),
        .p   (prod_y)
    );

    gte_mul u_mul_z (
        .clk (clk),
        .en  (en),
        .a   (gte_abs(h2)),
        .b   (gte_abs(rec_out[STEP_M].sl)),
        .rnd (RND80),
        .p   (prod_z)
    );

    always_comb
    begin
        ecef_x_next = rec_out[STEP_X].xneg ? $signed(34'd0 - prod[STEP_X][113:80])
                                           : $signed(prod[STEP_X][113:80]);
        ecef_y_next = rec_out[STEP_X].yneg ? $signed(34'd0 - prod_y[113:80])
                                           : $signed(prod_y[113:80]);
        ecef_z_next = rec_out[STEP_X].zneg ? $signed(34'd0 - prod_z[113:80])
                                           : $signed(prod_z[113:80]);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= rec_out[STEP_X].valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            ecef_x_reg <= ecef_x_next;
            ecef_y_reg <= ecef_y_next;
            ecef_z_reg <= ecef_z_next;
        end
    end

    assign ecef.valid  = out_valid_reg;
    assign ecef.ecef_x = ecef_x_reg;
    assign ecef.ecef_y = ecef_y_reg;
    assign ecef.ecef_z = ecef_z_reg;

    `GTE_ASSERT_IMP(a_ready_only_on_stall, clk, rst_n, !fix.ready, ecef.valid && !ecef.ready)
    `GTE_ASSERT_NEXT(a_out_load, clk, rst_n, en && rec_out[STEP_X].valid, out_valid_reg)
    `GTE_ASSERT_NEXT(a_pipe_frozen, clk, rst_n, !en, $stable(rec_out[STEP_X]))

endmodule
`default_nettype wire
